@@ rtl/fbc_pkg.sv @@
// Shared types, constants and plane coefficient function for the frustum box cull block.
`default_nettype none
package fbc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int NUM_REGS   = 8;
	localparam int NUM_CELLS  = 4;
	localparam int NUM_LANES  = 4;
	localparam int REG_W      = 64;
	localparam int IDX_W      = $clog2(NUM_REGS);
	localparam int COORD_W    = 32;
	localparam int HALF_W     = 31;
	localparam int COEF_W     = 33;
	localparam int PC_W       = COEF_W + COORD_W;
	localparam int PH_W       = COEF_W + HALF_W;
	localparam int ACC_W      = 70;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [HALF_W-1:0]         half_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [REG_W-1:0]          reg_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;

	localparam coord_t ONE_Q16 = 32'sh0001_0000;

	localparam reg_t REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	typedef enum logic [1:0] {
		ROW_X = 2'd0,
		ROW_Y = 2'd1,
		ROW_Z = 2'd2,
		ROW_W = 2'd3
	} row_t;

	localparam row_t PLANE_ROW [NUM_PLANES] = '{ROW_X, ROW_X, ROW_Y, ROW_Y, ROW_Z, ROW_Z};
	localparam logic PLANE_ADD [NUM_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	typedef struct packed {
		acc_t  [NUM_PLANES-1:0] acc;
		coord_t [NUM_LANES-1:0] c;
		half_t  [NUM_LANES-1:0] h;
	} cell_word_t;

	function automatic coef_t row_val(reg_t rows01, reg_t rows23, row_t row);
		logic [31:0] v;
		case (row)
			ROW_X:   v = rows01[31:0];
			ROW_Y:   v = rows01[63:32];
			ROW_Z:   v = rows23[31:0];
			ROW_W:   v = rows23[63:32];
			default: v = rows23[63:32];
		endcase
		return coef_t'({v[31], v});
	endfunction

	function automatic coef_t plane_coef(reg_t rows01, reg_t rows23, int plane);
		coef_t base;
		coef_t other;
		base  = row_val(rows01, rows23, ROW_W);
		other = row_val(rows01, rows23, PLANE_ROW[plane]);
		return PLANE_ADD[plane] ? coef_t'(base + other) : coef_t'(base - other);
	endfunction

endpackage
`default_nettype wire

@@ rtl/fbc_if.sv @@
// Valid/ready channel interfaces for box words and cull result words.
`default_nettype none
interface fbc_box_if;
	logic            valid;
	logic            ready;
	fbc_pkg::coord_t center_x;
	fbc_pkg::coord_t center_y;
	fbc_pkg::coord_t center_z;
	fbc_pkg::half_t  half_x;
	fbc_pkg::half_t  half_y;
	fbc_pkg::half_t  half_z;

	modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
		input ready);
	modport sink (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
		output ready);
endinterface

interface fbc_result_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

@@ rtl/fbc_cell.sv @@
// One matrix-column cell: multiply the head lane by six plane coefficients and accumulate.
`default_nettype none
module fbc_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fbc_pkg::reg_t       rows01,
	input  wire fbc_pkg::reg_t       rows23,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fbc_pkg::cell_word_t in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fbc_pkg::cell_word_t      out_word
);
	import fbc_pkg::*;

	logic                          adv_s1;
	logic                          adv_s2;
	logic                          valid_s1;
	logic                          valid_s2;
	cell_word_t                    word_s1;
	cell_word_t                    word_s2;
	cell_word_t                    shifted;
	cell_word_t                    sum_word;
	logic signed [PC_W-1:0]        pc_s1 [NUM_PLANES];
	logic [PH_W-1:0]               ph_s1 [NUM_PLANES];
	logic signed [PC_W-1:0]        pc    [NUM_PLANES];
	logic [PH_W-1:0]               ph    [NUM_PLANES];
	coef_t                         p     [NUM_PLANES];
	logic [COEF_W-1:0]             pm    [NUM_PLANES];

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			p[i]  = plane_coef(rows01, rows23, i);
			pm[i] = p[i][COEF_W-1] ? COEF_W'(-p[i]) : COEF_W'(p[i]);
			pc[i] = PC_W'(p[i] * in_word.c[0]);
			ph[i] = PH_W'(pm[i] * in_word.h[0]);
		end
	end

	// advance lanes: drop the consumed head, pad with the constant term lane
	always_comb begin
		shifted = in_word;
		for (int j = 0; j < NUM_LANES - 1; j++) begin
			shifted.c[j] = in_word.c[j+1];
			shifted.h[j] = in_word.h[j+1];
		end
		shifted.c[NUM_LANES-1] = ONE_Q16;
		shifted.h[NUM_LANES-1] = '0;
	end

	always_comb begin
		sum_word = word_s1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			sum_word.acc[i] = acc_t'($signed(word_s1.acc[i])
				+ $signed({{(ACC_W-PC_W){pc_s1[i][PC_W-1]}}, pc_s1[i]})
				+ $signed({{(ACC_W-PH_W){1'b0}}, ph_s1[i]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= shifted;
			for (int i = 0; i < NUM_PLANES; i++) begin
				pc_s1[i] <= pc[i];
				ph_s1[i] <= ph[i];
			end
		end
		if (adv_s2 && valid_s1) begin
			word_s2 <= sum_word;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule
`default_nettype wire

@@ rtl/frustum_box_cull.sv @@
// Top level: view frustum culling of axis-aligned boxes against a configured matrix.
//
// Box words arrive on the box channel (centre and half extents, Q16.16) and one
// result word per box leaves on the result channel: visible is 0 when some clip
// plane has all eight box corners on or outside it, else 1.
// The view-projection matrix sits in eight 64-bit registers written through
// wr_en/wr_index/wr_data; write them only while no box is in flight.
// A chain of four cells, one per matrix column, accumulates the six plane values;
// each cell has a multiply stage and an accumulate stage, then one output stage
// turns the six sums into visible.
// Throughput: one box per cycle while the receiver takes results, set by the two-stage
// cells.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, results back up stage by stage; the box channel keeps
// accepting words until every stage holds one, and nothing is lost.
`default_nettype none
module frustum_box_cull (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire fbc_pkg::reg_idx_t wr_index,
	input  wire fbc_pkg::reg_t     wr_data,
	fbc_box_if.sink                box,
	fbc_result_if.source           result
);
	import fbc_pkg::*;

	reg_t       regs_q [NUM_REGS];
	logic       chain_valid [NUM_CELLS+1];
	logic       chain_ready [NUM_CELLS+1];
	cell_word_t chain_word  [NUM_CELLS+1];
	cell_word_t head_word;
	logic       out_adv;
	logic       visible_d;
	logic       valid_q;
	logic       visible_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) regs_q[r] <= REG_RESET[r];
		end else if (wr_en) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	always_comb begin
		head_word = '0;
		head_word.c[0] = box.center_x;
		head_word.c[1] = box.center_y;
		head_word.c[2] = box.center_z;
		head_word.c[3] = ONE_Q16;
		head_word.h[0] = box.half_x;
		head_word.h[1] = box.half_y;
		head_word.h[2] = box.half_z;
		head_word.h[3] = '0;
	end

	assign chain_valid[0] = box.valid;
	assign chain_word[0]  = head_word;
	assign box.ready      = chain_ready[0];

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		fbc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.rows01    (regs_q[2*k]),
			.rows23    (regs_q[2*k+1]),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_word   (chain_word[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_word  (chain_word[k+1])
		);
	end

	assign out_adv                = !valid_q || result.ready;
	assign chain_ready[NUM_CELLS] = out_adv;

	always_comb begin
		visible_d = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (chain_word[NUM_CELLS].acc[i][ACC_W-1] || chain_word[NUM_CELLS].acc[i] == '0)
				visible_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_adv) begin
			valid_q <= chain_valid[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && chain_valid[NUM_CELLS]) visible_q <= visible_d;
	end

	assign result.valid   = valid_q;
	assign result.visible = visible_q;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> box.ready)
		else $error("box channel stalled with empty output stage");

	a_last_cell_holds: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NUM_CELLS] && !out_adv |=> chain_valid[NUM_CELLS])
		else $error("last cell word lost under stall");

	a_output_drains: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !chain_valid[NUM_CELLS] |=> !result.valid)
		else $error("result word repeated");

endmodule
`default_nettype wire

@@ bench/tb_frustum_box_cull.sv @@
// Testbench for frustum_box_cull: directed and random boxes checked against a plane-test predictor.
module tb_frustum_box_cull;
	timeunit 1ns;
	timeprecision 1ps;

	import fbc_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int PHASES       = 12;
	localparam int PHASE_BOXES  = 162;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 12;

	localparam int CUT_ROW [NUM_PLANES] = '{0, 0, 1, 1, 2, 2};
	localparam bit CUT_ADD [NUM_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	typedef enum logic [2:0] {
		SET_IDENT,
		SET_ZERO,
		SET_FLAT,
		SET_ONES,
		SET_MAXPOS,
		SET_MAXNEG,
		SET_PERSP,
		SET_RAND
	} setting_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		half_t  hx;
		half_t  hy;
		half_t  hz;
	} box_t;

	typedef struct packed {
		setting_t setting;
		box_t     box;
		logic     typed;
		logic     want;
	} dir_row_t;

	localparam coord_t C0   = 32'sh0000_0000;
	localparam coord_t CP1  = 32'sh0001_0000;
	localparam coord_t CN1  = 32'shFFFF_0000;
	localparam coord_t CP2  = 32'sh0002_0000;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;
	localparam coord_t CMIN = 32'sh8000_0000;
	localparam half_t  H0   = 31'h0;
	localparam half_t  HMAX = 31'h7FFF_FFFF;

	localparam int NUM_DIRECTED = 20;
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		'{SET_IDENT, '{C0, C0, C0, H0, H0, H0}, 1'b1, 1'b1},
		'{SET_IDENT, '{CP1, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{CN1, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{C0, CP1, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{C0, C0, CN1, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{CMAX, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{CMIN, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{C0, CMAX, CMIN, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_IDENT, '{CMAX, CMAX, CMAX, HMAX, HMAX, HMAX}, 1'b1, 1'b1},
		'{SET_IDENT, '{C0, C0, C0, HMAX, HMAX, HMAX}, 1'b1, 1'b1},
		'{SET_IDENT, '{CP2, C0, C0, 31'h0001_8000, H0, H0}, 1'b0, 1'b0},
		'{SET_IDENT, '{CP2, C0, C0, 31'h0001_0000, H0, H0}, 1'b0, 1'b0},
		'{SET_IDENT, '{CMIN, CMIN, CMIN, HMAX, HMAX, HMAX}, 1'b0, 1'b0},
		'{SET_IDENT, '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_8000,
			31'h2AAA_AAAA, 31'h5555_5555, 31'h0000_4000}, 1'b0, 1'b0},
		'{SET_IDENT, '{32'sh0000_8000, 32'shFFFF_8000, 32'sh0000_7FFF,
			31'h1, 31'h1, 31'h1}, 1'b0, 1'b0},
		'{SET_ZERO, '{C0, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_ZERO, '{CMAX, CMAX, CMAX, HMAX, HMAX, HMAX}, 1'b1, 1'b0},
		'{SET_FLAT, '{C0, C0, C0, H0, H0, H0}, 1'b1, 1'b0},
		'{SET_FLAT, '{C0, C0, C0, HMAX, HMAX, HMAX}, 1'b1, 1'b0},
		'{SET_IDENT, '{32'sh0000_4000, 32'sh0000_4000, 32'sh0000_4000, H0, H0, H0},
			1'b0, 1'b0}
	};

	logic     clk = 1'b0;
	logic     arst_n;
	logic     wr_en;
	reg_idx_t wr_index;
	reg_t     wr_data;

	fbc_box_if    box_ch ();
	fbc_result_if res_ch ();

	frustum_box_cull dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.box      (box_ch),
		.result   (res_ch)
	);

	reg_t cfg_shadow [NUM_REGS];
	bit   visible_due [$];
	int   mismatches;
	int   cycles;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   stall_req;
	int   stall_seen;
	int   hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [127:0] wide_entry(int col, int row);
		reg_t        w;
		logic [31:0] v;
		w = cfg_shadow[2 * col + row / 2];
		v = (row % 2 == 1) ? w[63:32] : w[31:0];
		return {{96{v[31]}}, v};
	endfunction

	function automatic bit box_visible(box_t b);
		logic signed [127:0] cen [3];
		logic signed [127:0] hal [3];
		logic signed [127:0] coef [4];
		logic signed [127:0] acc;
		bit                  vis;
		cen[0] = {{96{b.cx[31]}}, b.cx};
		cen[1] = {{96{b.cy[31]}}, b.cy};
		cen[2] = {{96{b.cz[31]}}, b.cz};
		hal[0] = {97'b0, b.hx};
		hal[1] = {97'b0, b.hy};
		hal[2] = {97'b0, b.hz};
		vis = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			for (int k = 0; k < 4; k++) begin
				coef[k] = CUT_ADD[i] ? wide_entry(k, 3) + wide_entry(k, CUT_ROW[i])
					: wide_entry(k, 3) - wide_entry(k, CUT_ROW[i]);
			end
			acc = coef[3] <<< 16;
			for (int k = 0; k < 3; k++) begin
				acc += coef[k] * cen[k] + ((coef[k] < 0) ? -coef[k] : coef[k]) * hal[k];
			end
			if (!(acc > 0)) begin
				vis = 1'b0;
			end
		end
		return vis;
	endfunction

	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(9);
		if (pick < 7) begin
			return coord_t'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
		end
		return coord_t'($urandom);
	endfunction

	function automatic half_t rand_half();
		int pick;
		pick = $urandom_range(9);
		if (pick < 2) begin
			return '0;
		end
		if (pick < 8) begin
			return half_t'($urandom_range(0, 32'h0004_0000));
		end
		return half_t'($urandom);
	endfunction

	function automatic logic [31:0] rand_entry();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return '0;
		end
		if (pick == 1) begin
			return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		return rand_coord();
	endfunction

	function automatic box_t rand_box();
		box_t b;
		b.cx = rand_coord();
		b.cy = rand_coord();
		b.cz = rand_coord();
		b.hx = rand_half();
		b.hy = rand_half();
		b.hz = rand_half();
		return b;
	endfunction

	function automatic reg_t setting_word(setting_t s, int idx);
		case (s)
			SET_IDENT:  return REG_RESET[idx];
			SET_ZERO:   return '0;
			SET_FLAT: begin
				if (idx == 1) return 64'h0001_0000_0000_0000;
				if (idx == 7) return 64'h0;
				return REG_RESET[idx];
			end
			SET_ONES:   return '1;
			SET_MAXPOS: return {2{32'h7FFF_FFFF}};
			SET_MAXNEG: return {2{32'h8000_0000}};
			SET_PERSP: begin
				case (idx)
					0:       return 64'h0000_0000_0001_0000;
					2:       return 64'h0001_0000_0000_0000;
					5:       return 64'hFFFF_0000_FFFF_0000;
					7:       return 64'h0000_0000_FFFF_CCCD;
					default: return 64'h0;
				endcase
			end
			default:    return {rand_entry(), rand_entry()};
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic send_box(box_t b, bit typed, bit want);
		while ($urandom_range(99) < send_idle_pct) begin
			box_ch.valid <= 1'b0;
			@(posedge clk);
		end
		box_ch.valid    <= 1'b1;
		box_ch.center_x <= b.cx;
		box_ch.center_y <= b.cy;
		box_ch.center_z <= b.cz;
		box_ch.half_x   <= b.hx;
		box_ch.half_y   <= b.hy;
		box_ch.half_z   <= b.hz;
		@(posedge clk);
		while (!box_ch.ready) begin
			@(posedge clk);
		end
		visible_due.push_back(typed ? want : box_visible(b));
	endtask

	task automatic drain_results();
		box_ch.valid <= 1'b0;
		@(posedge clk);
		while (visible_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic load_setting(setting_t s);
		reg_t w;
		drain_results();
		for (int i = 0; i < NUM_REGS; i++) begin
			w = setting_word(s, i);
			wr_en    <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data  <= w;
			@(posedge clk);
			cfg_shadow[i] = w;
		end
		wr_en <= 1'b0;
	endtask

	function automatic setting_t phase_setting(int p);
		case (p)
			0:       return SET_IDENT;
			1:       return SET_PERSP;
			2:       return SET_ONES;
			4:       return SET_MAXPOS;
			5:       return SET_PERSP;
			6:       return SET_MAXNEG;
			8:       return SET_ZERO;
			10:      return SET_PERSP;
			default: return SET_RAND;
		endcase
	endfunction

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (visible_due.size() == 0) begin
				report_mismatch("result word with none pending", res_ch.visible, -1);
			end else if (res_ch.visible !== visible_due[0]) begin
				report_mismatch("visible", res_ch.visible, visible_due.pop_front());
			end else begin
				void'(visible_due.pop_front());
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL frustum_box_cull");
		$finish;
	end

	initial begin
		setting_t cur;
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= '0;
		wr_data         <= '0;
		box_ch.valid    <= 1'b0;
		box_ch.center_x <= '0;
		box_ch.center_y <= '0;
		box_ch.center_z <= '0;
		box_ch.half_x   <= '0;
		box_ch.half_y   <= '0;
		box_ch.half_z   <= '0;
		mismatches      = 0;
		stall_req       = 0;
		stall_seen      = 0;
		hold_left       = 0;
		send_idle_pct   = 18;
		recv_idle_pct   = 69;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_shadow[i] = REG_RESET[i];
		end
		cur = SET_IDENT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].setting != cur) begin
				cur = DIRECTED[i].setting;
				load_setting(cur);
			end
			send_box(DIRECTED[i].box, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p * 3 / PHASES)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_setting(phase_setting(p));
			if (p == 5 || p == 9) begin
				stall_req++;
			end
			for (int n = 0; n < PHASE_BOXES; n++) begin
				send_box(rand_box(), 1'b0, 1'b0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS frustum_box_cull");
		end else begin
			$display("FAIL frustum_box_cull");
		end
		$finish;
	end

endmodule
